FILE: rtl/wbps_pkg.sv
// ============================================================================
// Wildcard byte pattern search - shared definitions
// Register indexes, field widths and the result record for the search block.
// ============================================================================
package wbps_pkg;

  // Pattern storage: four 64-bit words of eight bytes each
  localparam int PATTERN_WORDS = 4;
  localparam int WORD_W        = 64;
  localparam int PATTERN_BYTES = PATTERN_WORDS * 8;

  // Configuration channel
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int LENGTH_W    = 6;

  // Stream fields
  localparam int BYTE_W   = 8;
  localparam int OFFSET_W = 32;

  // Pattern byte that matches any data byte
  localparam logic [BYTE_W-1:0] WILDCARD = 8'h2A;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_WORD0  = 3'd0,
    REG_PATTERN_WORD1  = 3'd1,
    REG_PATTERN_WORD2  = 3'd2,
    REG_PATTERN_WORD3  = 3'd3,
    REG_PATTERN_LENGTH = 3'd4
  } cfg_reg_t;

  // One result transaction
  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
  } result_t;

endpackage

FILE: rtl/wildcard_byte_pattern_search.sv
// ============================================================================
// Wildcard byte pattern search
// Streams a memory region one byte per transaction and reports the offset of
// the first place where a configured pattern (0x2A = any byte) matches.
// ============================================================================
// The block takes one region byte in every clock cycle while s_tready is
// high. Each accepted byte is shifted into a window of the newest MAX_PATTERN
// bytes and the whole window is compared against the pattern in the same
// cycle, and any result it causes is registered. At most one result per
// region: found=1 with the offset of the first matching byte, or found=0 on
// the region's tlast byte when nothing matched. Bytes after a match are
// swallowed until tlast, which clears the window and the byte count. A result
// register plus one skid entry sit on the output; s_tready drops only while
// two results wait for the downstream side. Configuration writes are taken
// in any cycle (cfg_ready is always high) and must be made between items.
module wildcard_byte_pattern_search #(
  parameter int MAX_PATTERN = 32,
  parameter int OFFSET_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wbps_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Region byte stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [wbps_pkg::BYTE_W-1:0]          s_tdata,   // [7:0] data_byte
  input  logic                                 s_tlast,   // region_end
  // Search result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [wbps_pkg::OFFSET_W-1:0]        m_tdata,   // [31:0] match_offset
  output logic                                 m_tuser    // [0] found
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  // Wide enough for both the length register and MAX_PATTERN
  localparam int CMP_W = ((LEN_W > wbps_pkg::LENGTH_W) ? LEN_W : wbps_pkg::LENGTH_W) + 1;

  // Configuration registers
  logic [wbps_pkg::PATTERN_WORDS-1:0][wbps_pkg::WORD_W-1:0] pattern_words;
  logic [wbps_pkg::LENGTH_W-1:0]                            pattern_length;

  // Region state
  logic [MAX_PATTERN-1:0][wbps_pkg::BYTE_W-1:0] recent_bytes;
  logic [MAX_PATTERN-1:0][wbps_pkg::BYTE_W-1:0] recent_bytes_next;
  logic [OFFSET_BITS-1:0]                       bytes_seen;
  logic [OFFSET_BITS-1:0]                       bytes_seen_next;
  logic                                         already_reported;

  // Output result register and skid entry
  logic               out_valid;
  wbps_pkg::result_t  out_res;
  logic               skid_valid;
  wbps_pkg::result_t  skid_res;

  // Match datapath
  logic [MAX_PATTERN-1:0][wbps_pkg::BYTE_W-1:0] pat_bytes;
  logic [MAX_PATTERN*wbps_pkg::BYTE_W-1:0]      pat_reversed;
  logic [MAX_PATTERN*wbps_pkg::BYTE_W-1:0]      pat_aligned;
  logic [CMP_W-1:0]                             len_ext;
  logic [LEN_W-1:0]                             active_len;
  logic [LEN_W-1:0]                             align_shift;
  logic [MAX_PATTERN-1:0]                       byte_ok;
  logic                                         window_match;
  logic                                         enough_bytes;
  logic [OFFSET_BITS-1:0]                       offset_full;

  logic               in_accept;
  logic               out_pop;
  logic               res_valid;
  wbps_pkg::result_t  res;

  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;
  assign out_pop   = out_valid && m_tready;
  assign s_tready  = !skid_valid;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_res.offset;
  assign m_tuser  = out_res.found;

  // Configuration register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_words  <= '0;
      pattern_length <= wbps_pkg::LENGTH_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (wbps_pkg::cfg_reg_t'(cfg_index))
        wbps_pkg::REG_PATTERN_WORD0:  pattern_words[0] <= cfg_data;
        wbps_pkg::REG_PATTERN_WORD1:  pattern_words[1] <= cfg_data;
        wbps_pkg::REG_PATTERN_WORD2:  pattern_words[2] <= cfg_data;
        wbps_pkg::REG_PATTERN_WORD3:  pattern_words[3] <= cfg_data;
        wbps_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[wbps_pkg::LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack pattern bytes; bytes past the register file read as zero
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
    if (k < wbps_pkg::PATTERN_BYTES) begin : g_reg
      assign pat_bytes[k] = pattern_words[k / 8][(k % 8) * 8 +: 8];
    end else begin : g_zero
      assign pat_bytes[k] = '0;
    end
  end

  // Clamp the length to 1..MAX_PATTERN
  always_comb begin
    len_ext = CMP_W'(pattern_length);
    if (pattern_length == '0) begin
      active_len = LEN_W'(1);
    end else if (len_ext > CMP_W'(MAX_PATTERN)) begin
      active_len = LEN_W'(MAX_PATTERN);
    end else begin
      active_len = len_ext[LEN_W-1:0];
    end
    align_shift = LEN_W'(MAX_PATTERN) - active_len;
  end

  // Reverse the pattern and shift it so that window entry j lines up with
  // pattern byte (length - 1 - j)
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pat_reversed[i*8 +: 8] = pat_bytes[MAX_PATTERN-1-i];
    end
    pat_aligned = pat_reversed >> {align_shift, 3'b000};
  end

  // Window after this byte and the saturating byte count
  always_comb begin
    recent_bytes_next[0] = s_tdata;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      recent_bytes_next[j] = recent_bytes[j-1];
    end
    if (bytes_seen != '1) begin
      bytes_seen_next = bytes_seen + OFFSET_BITS'(1);
    end else begin
      bytes_seen_next = bytes_seen;
    end
  end

  // Compare every window entry against its aligned pattern byte
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (LEN_W'(j) < active_len && pat_aligned[j*8 +: 8] != wbps_pkg::WILDCARD) begin
        byte_ok[j] = (pat_aligned[j*8 +: 8] == recent_bytes_next[j]);
      end else begin
        byte_ok[j] = 1'b1;
      end
    end
    window_match = &byte_ok;
    enough_bytes = (bytes_seen_next >= OFFSET_BITS'(active_len));
    offset_full  = bytes_seen_next - OFFSET_BITS'(active_len);
  end

  // Decide whether this transaction produces a result
  always_comb begin
    res_valid  = 1'b0;
    res.found  = 1'b0;
    res.offset = '0;
    if (in_accept && !already_reported) begin
      if (enough_bytes && window_match) begin
        res_valid  = 1'b1;
        res.found  = 1'b1;
        res.offset = wbps_pkg::OFFSET_W'(offset_full);
      end else if (s_tlast) begin
        res_valid = 1'b1;
      end
    end
  end

  // Advance region state; tlast clears it
  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes     <= '0;
      bytes_seen       <= '0;
      already_reported <= 1'b0;
    end else if (in_accept) begin
      if (s_tlast) begin
        recent_bytes     <= '0;
        bytes_seen       <= '0;
        already_reported <= 1'b0;
      end else if (!already_reported) begin
        recent_bytes     <= recent_bytes_next;
        bytes_seen       <= bytes_seen_next;
        already_reported <= enough_bytes && window_match;
      end
    end
  end

  // Output register and skid entry: control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_pop) begin
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid && !out_pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  // Output register and skid entry: payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_pop) begin
        out_res <= skid_res;
      end
    end else if (res_valid) begin
      if (out_valid && !out_pop) begin
        skid_res <= res;
      end else begin
        out_res <= res;
      end
    end
  end

endmodule
